// ===== rtl/skrf_pkg.sv =====
// -----------------------------------------------------------------------------
// skrf_pkg: shared types, constants and microprogram
// Payload and configuration types, datapath operation codes, sequencer jump
// kinds and the control store of the scalar Kalman rate filter.
// -----------------------------------------------------------------------------
package skrf_pkg;

   // Fixed-point format of rates and variances
   localparam int FRAC_BITS = 16;

   // Register indexes on the configuration port
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_INITIAL_VARIANCE     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MOTION_VARIANCE      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MEASUREMENT_VARIANCE = 2'd2;

   // Saturate a 64-bit unsigned value into 32 bits
   function automatic logic [31:0] sat_u32(input logic [63:0] x);
      logic [31:0] res;
      res = (x[63:32] != 32'd0) ? 32'hFFFF_FFFF : x[31:0];
      return res;
   endfunction

   // Register defaults: 1000.0, 4.0 and 0.5
   localparam logic [63:0] IV_WIDE = 64'd1000 << FRAC_BITS;
   localparam logic [63:0] MV_WIDE = 64'd4 << FRAC_BITS;
   localparam logic [63:0] MR_WIDE = 64'd1 << (FRAC_BITS - 1);
   localparam logic [31:0] INITIAL_VARIANCE_RST     = sat_u32(IV_WIDE);
   localparam logic [31:0] MOTION_VARIANCE_RST      = sat_u32(MV_WIDE);
   localparam logic [31:0] MEASUREMENT_VARIANCE_RST = sat_u32(MR_WIDE);

   // Divider: one quotient bit per step
   localparam int DIV_STEPS = 32;
   localparam int LOOP_W    = $clog2(DIV_STEPS);

   // Request and response payloads
   typedef struct packed {
      logic               func;
      logic signed [31:0] rate_value;
   } req_payload_type;

   typedef struct packed {
      logic signed [31:0] filtered_rate;
      logic [31:0]        estimate_variance;
   } rsp_payload_type;

   // Configuration register set
   typedef struct packed {
      logic [31:0] initial_variance;
      logic [31:0] motion_variance;
      logic [31:0] measurement_variance;
   } cfg_type;

   // Datapath operations
   typedef enum logic [4:0] {
      OP_NOP,
      OP_LOAD_IN,
      OP_STORE_Z,
      OP_SEED,
      OP_PREDICT,
      OP_SUM,
      OP_MUL_MR,
      OP_MUL_ZP,
      OP_ADD,
      OP_DIV_LOAD_MEAN,
      OP_DIV_STEP,
      OP_MEAN_WB,
      OP_MUL_PR,
      OP_DIV_LOAD_VAR,
      OP_VAR_WB,
      OP_VAR_ZERO,
      OP_EMIT
   } op_type;

   // Sequencer jump kinds
   typedef enum logic [2:0] {
      J_NEXT,
      J_GOTO,
      J_IF_IMU,
      J_IF_SEED,
      J_IF_SZERO,
      J_LOOP,
      J_WAIT_REQ,
      J_WAIT_OUT
   } jump_type;

   localparam int PC_W = 5;

   typedef struct packed {
      op_type          op;
      jump_type        jump;
      logic [PC_W-1:0] target;
      logic            load_loop;
   } ucode_type;

   // Flags the sequencer branches on
   typedef struct packed {
      logic req_valid;
      logic out_busy;
      logic is_imu;
      logic awaiting;
      logic szero;
   } seq_status_type;

   // Step addresses
   localparam logic [PC_W-1:0] ST_IDLE      = 5'd0;
   localparam logic [PC_W-1:0] ST_KIND      = 5'd1;
   localparam logic [PC_W-1:0] ST_FIRST     = 5'd2;
   localparam logic [PC_W-1:0] ST_PREDICT   = 5'd3;
   localparam logic [PC_W-1:0] ST_SUM       = 5'd4;
   localparam logic [PC_W-1:0] ST_MUL_MR    = 5'd5;
   localparam logic [PC_W-1:0] ST_MUL_ZP    = 5'd6;
   localparam logic [PC_W-1:0] ST_ADD       = 5'd7;
   localparam logic [PC_W-1:0] ST_DIVL_MEAN = 5'd8;
   localparam logic [PC_W-1:0] ST_DIV_MEAN  = 5'd9;
   localparam logic [PC_W-1:0] ST_MEAN_WB   = 5'd10;
   localparam logic [PC_W-1:0] ST_MUL_PR    = 5'd11;
   localparam logic [PC_W-1:0] ST_DIVL_VAR  = 5'd12;
   localparam logic [PC_W-1:0] ST_DIV_VAR   = 5'd13;
   localparam logic [PC_W-1:0] ST_VAR_WB    = 5'd14;
   localparam logic [PC_W-1:0] ST_EMIT      = 5'd15;
   localparam logic [PC_W-1:0] ST_IMU       = 5'd16;
   localparam logic [PC_W-1:0] ST_SEED      = 5'd17;
   localparam logic [PC_W-1:0] ST_VAR_ZERO  = 5'd18;

   // Control store
   function automatic ucode_type ucode_rom(input logic [PC_W-1:0] addr);
      ucode_type w;
      case (addr)
         ST_IDLE:      w = '{OP_LOAD_IN,       J_WAIT_REQ, ST_KIND,      1'b0};
         ST_KIND:      w = '{OP_NOP,           J_IF_IMU,   ST_IMU,       1'b0};
         ST_FIRST:     w = '{OP_NOP,           J_IF_SEED,  ST_SEED,      1'b0};
         ST_PREDICT:   w = '{OP_PREDICT,       J_NEXT,     ST_IDLE,      1'b0};
         ST_SUM:       w = '{OP_SUM,           J_IF_SZERO, ST_VAR_ZERO,  1'b0};
         ST_MUL_MR:    w = '{OP_MUL_MR,        J_NEXT,     ST_IDLE,      1'b0};
         ST_MUL_ZP:    w = '{OP_MUL_ZP,        J_NEXT,     ST_IDLE,      1'b0};
         ST_ADD:       w = '{OP_ADD,           J_NEXT,     ST_IDLE,      1'b0};
         ST_DIVL_MEAN: w = '{OP_DIV_LOAD_MEAN, J_NEXT,     ST_IDLE,      1'b1};
         ST_DIV_MEAN:  w = '{OP_DIV_STEP,      J_LOOP,     ST_DIV_MEAN,  1'b0};
         ST_MEAN_WB:   w = '{OP_MEAN_WB,       J_NEXT,     ST_IDLE,      1'b0};
         ST_MUL_PR:    w = '{OP_MUL_PR,        J_NEXT,     ST_IDLE,      1'b0};
         ST_DIVL_VAR:  w = '{OP_DIV_LOAD_VAR,  J_NEXT,     ST_IDLE,      1'b1};
         ST_DIV_VAR:   w = '{OP_DIV_STEP,      J_LOOP,     ST_DIV_VAR,   1'b0};
         ST_VAR_WB:    w = '{OP_VAR_WB,        J_NEXT,     ST_IDLE,      1'b0};
         ST_EMIT:      w = '{OP_EMIT,          J_WAIT_OUT, ST_IDLE,      1'b0};
         ST_IMU:       w = '{OP_STORE_Z,       J_GOTO,     ST_IDLE,      1'b0};
         ST_SEED:      w = '{OP_SEED,          J_GOTO,     ST_IDLE,      1'b0};
         ST_VAR_ZERO:  w = '{OP_VAR_ZERO,      J_GOTO,     ST_EMIT,      1'b0};
         default:      w = '{OP_NOP,           J_GOTO,     ST_IDLE,      1'b0};
      endcase
      return w;
   endfunction

endpackage

// ===== rtl/scalar_kalman_rate_filter.sv =====
// -----------------------------------------------------------------------------
// scalar_kalman_rate_filter: scalar Kalman filter on a yaw rate
// Top level: request and response handshakes, configuration registers,
// response register, sequencer and datapath.
// -----------------------------------------------------------------------------
// Filters a yaw rate in signed Q16.16. An imu request (func 0) stores the
// measured rate; the first odometry request (func 1) seeds the estimate.
// Every later odometry request predicts, fuses the stored imu rate through the
// 32-step restoring divider, run once for the mean and once for the variance,
// and the shared multiplier, and returns one response; if the predicted variance
// and the measurement variance are both zero, the variance is cleared and the
// predicted mean is returned unfused. Requests are taken one at a time; a
// finished response waits in its own register, so a new request may be taken
// while it is held. A second response stalls the filter until the first
// has gone. Write the configuration only while the filter is idle.
module scalar_kalman_rate_filter import skrf_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_payload_type      req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_payload_type      rsp_payload,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_wr_data
);

   cfg_type         cfg_ff, cfg_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;
   seq_status_type  status;
   op_type          op;
   logic            idle;
   logic            is_imu, awaiting, szero;
   rsp_payload_type result;

   assign req_ready   = idle;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   assign status = '{req_valid: req_valid,
                     out_busy:  rsp_valid_ff && !rsp_ready,
                     is_imu:    is_imu,
                     awaiting:  awaiting,
                     szero:     szero};

   skrf_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .op     (op),
      .idle   (idle)
   );

   skrf_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .op          (op),
      .req_payload (req_payload),
      .cfg         (cfg_ff),
      .is_imu      (is_imu),
      .awaiting    (awaiting),
      .szero       (szero),
      .result      (result)
   );

   // Configuration writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_INITIAL_VARIANCE:     cfg_in.initial_variance     = csr_wr_data;
            CSR_MOTION_VARIANCE:      cfg_in.motion_variance      = csr_wr_data;
            CSR_MEASUREMENT_VARIANCE: cfg_in.measurement_variance = csr_wr_data;
            default: ;
         endcase
      end
   end

   // Response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (op == OP_EMIT) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= '{initial_variance:     INITIAL_VARIANCE_RST,
                           motion_variance:      MOTION_VARIANCE_RST,
                           measurement_variance: MEASUREMENT_VARIANCE_RST};
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// ===== rtl/skrf_seq.sv =====
// -----------------------------------------------------------------------------
// skrf_seq: microcode sequencer
// Step counter over the control store, with conditional jumps, a loop
// counter for the divider and hold steps for the two handshakes.
// -----------------------------------------------------------------------------
module skrf_seq import skrf_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  seq_status_type status,
   output op_type         op,
   output logic           idle
);

   logic [PC_W-1:0]   pc_ff, pc_in;
   logic [LOOP_W-1:0] cnt_ff, cnt_in;
   ucode_type         word;
   logic              hold;

   assign word = ucode_rom(pc_ff);

   // Next step and loop count
   always_comb begin
      pc_in  = pc_ff + PC_W'(1);
      cnt_in = cnt_ff;
      case (word.jump)
         J_NEXT:     pc_in = pc_ff + PC_W'(1);
         J_GOTO:     pc_in = word.target;
         J_IF_IMU:   if (status.is_imu) pc_in = word.target;
         J_IF_SEED:  if (status.awaiting) pc_in = word.target;
         J_IF_SZERO: if (status.szero) pc_in = word.target;
         J_LOOP: begin
            if (cnt_ff != '0) begin
               pc_in  = word.target;
               cnt_in = cnt_ff - LOOP_W'(1);
            end
         end
         J_WAIT_REQ: pc_in = status.req_valid ? word.target : pc_ff;
         J_WAIT_OUT: pc_in = status.out_busy ? pc_ff : word.target;
         default:    pc_in = ST_IDLE;
      endcase
      if (word.load_loop) begin
         cnt_in = LOOP_W'(DIV_STEPS - 1);
      end
   end

   // Control outputs: the operation fires only once a hold step is released
   always_comb begin
      hold = ((word.jump == J_WAIT_REQ) && !status.req_valid) ||
             ((word.jump == J_WAIT_OUT) && status.out_busy);
      op   = hold ? OP_NOP : word.op;
      idle = (pc_ff == ST_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff  <= ST_IDLE;
         cnt_ff <= '0;
      end else begin
         pc_ff  <= pc_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ===== rtl/skrf_dp.sv =====
// -----------------------------------------------------------------------------
// skrf_dp: filter datapath
// Filter state, one shared 33x33 multiplier, an accumulator and a
// restoring divider that yields one quotient bit per step.
// -----------------------------------------------------------------------------
module skrf_dp import skrf_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  op_type          op,
   input  req_payload_type req_payload,
   input  cfg_type         cfg,
   output logic            is_imu,
   output logic            awaiting,
   output logic            szero,
   output rsp_payload_type result
);

   // Filter state
   logic signed [31:0] mean_ff, mean_in;
   logic [31:0]        var_ff, var_in;
   logic signed [31:0] prev_ff, prev_in;
   logic signed [31:0] z_ff, z_in;
   logic               await_ff, await_in;
   // Latched request
   logic               func_ff, func_in;
   logic signed [31:0] rate_ff, rate_in;
   // Working registers
   logic [32:0]        s_ff, s_in;
   logic signed [65:0] prod_ff, prod_in;
   logic signed [65:0] acc_ff, acc_in;
   logic [32:0]        rem_ff, rem_in;
   logic [31:0]        quo_ff, quo_in;
   logic               neg_ff, neg_in;

   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] mul_p;
   logic signed [32:0] delta;
   logic signed [33:0] mean_sum;
   logic [32:0]        var_sum;
   logic [65:0]        acc_mag;
   logic [34:0]        trial;
   logic               ge;

   assign is_imu   = !func_ff;
   assign awaiting = await_ff;
   assign szero    = (var_ff == 32'd0) && (cfg.measurement_variance == 32'd0);
   assign result   = '{filtered_rate: mean_ff, estimate_variance: var_ff};

   // Shared multiplier operands
   always_comb begin
      case (op)
         OP_MUL_MR: begin
            mul_a = {mean_ff[31], mean_ff};
            mul_b = {1'b0, cfg.measurement_variance};
         end
         OP_MUL_ZP: begin
            mul_a = {z_ff[31], z_ff};
            mul_b = {1'b0, var_ff};
         end
         default: begin
            mul_a = {1'b0, var_ff};
            mul_b = {1'b0, cfg.measurement_variance};
         end
      endcase
      mul_p = mul_a * mul_b;
   end

   // Prediction arithmetic
   always_comb begin
      delta    = {rate_ff[31], rate_ff} - {prev_ff[31], prev_ff};
      mean_sum = {{2{mean_ff[31]}}, mean_ff} + {delta[32], delta};
      var_sum  = {1'b0, var_ff} + {1'b0, cfg.motion_variance};
   end

   // Divider step and numerator magnitude
   always_comb begin
      acc_mag = acc_ff[65] ? 66'(-acc_ff) : acc_ff;
      trial   = {1'b0, rem_ff, quo_ff[31]} - {2'b00, s_ff};
      ge      = !trial[34];
   end

   // Operation decode
   always_comb begin
      mean_in  = mean_ff;
      var_in   = var_ff;
      prev_in  = prev_ff;
      z_in     = z_ff;
      await_in = await_ff;
      func_in  = func_ff;
      rate_in  = rate_ff;
      s_in     = s_ff;
      prod_in  = prod_ff;
      acc_in   = acc_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      neg_in   = neg_ff;
      case (op)
         OP_LOAD_IN: begin
            func_in = req_payload.func;
            rate_in = req_payload.rate_value;
         end
         OP_STORE_Z: z_in = rate_ff;
         OP_SEED: begin
            mean_in  = rate_ff;
            prev_in  = rate_ff;
            var_in   = cfg.initial_variance;
            await_in = 1'b0;
         end
         OP_PREDICT: begin
            prev_in = rate_ff;
            // saturate mean to the signed 32-bit range
            if ((mean_sum[33:31] == 3'b000) || (mean_sum[33:31] == 3'b111)) begin
               mean_in = mean_sum[31:0];
            end else if (mean_sum[33]) begin
               mean_in = 32'sh8000_0000;
            end else begin
               mean_in = 32'sh7FFF_FFFF;
            end
            var_in = var_sum[32] ? 32'hFFFF_FFFF : var_sum[31:0];
         end
         OP_SUM:    s_in = {1'b0, var_ff} + {1'b0, cfg.measurement_variance};
         OP_MUL_MR: prod_in = mul_p;
         OP_MUL_ZP: begin
            acc_in  = prod_ff;
            prod_in = mul_p;
         end
         OP_ADD:    acc_in = acc_ff + prod_ff;
         OP_DIV_LOAD_MEAN: begin
            neg_in = acc_ff[65];
            rem_in = acc_mag[64:32];
            quo_in = acc_mag[31:0];
         end
         OP_DIV_STEP: begin
            rem_in = ge ? trial[32:0] : {rem_ff[31:0], quo_ff[31]};
            quo_in = {quo_ff[30:0], ge};
         end
         OP_MEAN_WB: begin
            // weighted mean; quotient never exceeds 2^31 in magnitude
            if (neg_ff) begin
               mean_in = (quo_ff[31] && (quo_ff[30:0] != '0)) ? 32'sh8000_0000
                                                               : -$signed(quo_ff);
            end else begin
               mean_in = quo_ff[31] ? 32'sh7FFF_FFFF : $signed(quo_ff);
            end
         end
         OP_MUL_PR:  prod_in = mul_p;
         OP_DIV_LOAD_VAR: begin
            rem_in = {1'b0, prod_ff[63:32]};
            quo_in = prod_ff[31:0];
         end
         OP_VAR_WB:   var_in = quo_ff;
         OP_VAR_ZERO: var_in = 32'd0;
         default: ;
      endcase
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mean_ff  <= '0;
         var_ff   <= INITIAL_VARIANCE_RST;
         prev_ff  <= '0;
         z_ff     <= '0;
         await_ff <= 1'b1;
      end else begin
         mean_ff  <= mean_in;
         var_ff   <= var_in;
         prev_ff  <= prev_in;
         z_ff     <= z_in;
         await_ff <= await_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      func_ff <= func_in;
      rate_ff <= rate_in;
      s_ff    <= s_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      neg_ff  <= neg_in;
   end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_top: self-checking testbench for scalar_kalman_rate_filter
// Sends imu and odometry requests under random gaps and back-pressure, keeps
// its own fixed-point estimate of the filter and compares every response,
// field by field, with the oldest predicted estimate. Settings change between
// phases while the filter is idle.
// -----------------------------------------------------------------------------
module tb_top;
   import skrf_pkg::*;

   localparam logic                 FUNC_IMU        = 1'b0;
   localparam logic                 FUNC_ODOMETRY   = 1'b1;
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED    = 2'd3;
   localparam int                   DRAIN_CYCLES    = 100;
   localparam int                   HOLD_OFF_CYCLES = 600;
   localparam int                   HOLD_OFF_AT     = 150;
   localparam int                   RANDOM_PHASES   = 6;
   localparam int                   PHASE_ROUNDS    = 80;
   localparam int                   MAX_REPORTS     = 10;

   // Running Kalman estimate plus the queue of estimates still owed by the filter
   class kalman_rate_checker;
      logic [31:0]     initial_var_reg;
      logic [31:0]     motion_var_reg;
      logic [31:0]     meas_var_reg;
      logic [31:0]     est_mean;
      logic [31:0]     est_variance;
      logic [31:0]     prev_odo_rate;
      logic [31:0]     imu_rate;
      bit              awaiting_seed;
      rsp_payload_type expected_estimates[$];
      int              failures;
      int              responses_seen;

      function new();
         initial_var_reg = 32'h03E8_0000;   // 1000.0
         motion_var_reg  = 32'h0004_0000;   // 4.0
         meas_var_reg    = 32'h0000_8000;   // 0.5
         est_mean        = '0;
         est_variance    = initial_var_reg;
         prev_odo_rate   = '0;
         imu_rate        = '0;
         awaiting_seed   = 1'b1;
         failures        = 0;
         responses_seen  = 0;
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] index, logic [31:0] value);
         case (index)
            CSR_INITIAL_VARIANCE:     initial_var_reg = value;
            CSR_MOTION_VARIANCE:      motion_var_reg  = value;
            CSR_MEASUREMENT_VARIANCE: meas_var_reg    = value;
            default: ;
         endcase
      endfunction

      function int pending();
         return expected_estimates.size();
      endfunction

      // Predict on the odometry change, then fuse the stored imu rate
      function rsp_payload_type fuse_odometry(logic [31:0] rate);
         longint             mean_sum;
         logic [32:0]        var_sum;
         logic [32:0]        denom;
         logic signed [65:0] mean_ext, imu_ext, meas_ext, var_ext, numer;
         logic [65:0]        magnitude, quotient;
         logic [63:0]        var_product, var_quotient;
         bit                 negative;
         rsp_payload_type    res;

         mean_sum = longint'($signed(est_mean)) + longint'($signed(rate))
                    - longint'($signed(prev_odo_rate));
         prev_odo_rate = rate;
         if (mean_sum > 64'sh0000_0000_7FFF_FFFF) begin
            est_mean = 32'h7FFF_FFFF;
         end else if (mean_sum < 64'shFFFF_FFFF_8000_0000) begin
            est_mean = 32'h8000_0000;
         end else begin
            est_mean = mean_sum[31:0];
         end
         var_sum      = {1'b0, est_variance} + {1'b0, motion_var_reg};
         est_variance = var_sum[32] ? 32'hFFFF_FFFF : var_sum[31:0];

         // update: mean = (R*mean + P*z)/(P+R), var = P*R/(P+R), truncating
         denom = {1'b0, est_variance} + {1'b0, meas_var_reg};
         if (denom == 33'd0) begin
            est_variance = '0;
         end else begin
            mean_ext  = $signed(est_mean);
            imu_ext   = $signed(imu_rate);
            meas_ext  = {34'd0, meas_var_reg};
            var_ext   = {34'd0, est_variance};
            numer     = mean_ext * meas_ext + imu_ext * var_ext;
            negative  = numer < 0;
            magnitude = negative ? -numer : numer;
            quotient  = magnitude / {33'd0, denom};
            if (negative) begin
               est_mean = (quotient >= 66'h8000_0000) ? 32'h8000_0000 : -quotient[31:0];
            end else begin
               est_mean = (quotient >= 66'h8000_0000) ? 32'h7FFF_FFFF : quotient[31:0];
            end
            var_product  = {32'd0, est_variance} * {32'd0, meas_var_reg};
            var_quotient = var_product / {31'd0, denom};
            est_variance = (var_quotient[63:32] != 32'd0) ? 32'hFFFF_FFFF : var_quotient[31:0];
         end
         res.filtered_rate     = est_mean;
         res.estimate_variance = est_variance;
         return res;
      endfunction

      function void note_request(req_payload_type req);
         logic [31:0] rate;
         rate = req.rate_value;
         if (req.func == FUNC_IMU) begin
            imu_rate = rate;
         end else if (awaiting_seed) begin
            // first odometry only seeds the estimate
            est_mean      = rate;
            prev_odo_rate = rate;
            est_variance  = initial_var_reg;
            awaiting_seed = 1'b0;
         end else begin
            expected_estimates.push_back(fuse_odometry(rate));
         end
      endfunction

      function void check_response(rsp_payload_type got);
         rsp_payload_type want;
         responses_seen++;
         if (expected_estimates.size() == 0) begin
            failures++;
            if (failures <= MAX_REPORTS)
               $display("unexpected response %0d: rate %h variance %h",
                        responses_seen, got.filtered_rate, got.estimate_variance);
            return;
         end
         want = expected_estimates.pop_front();
         if (got.filtered_rate !== want.filtered_rate
             || got.estimate_variance !== want.estimate_variance) begin
            failures++;
            if (failures <= MAX_REPORTS)
               $display("response %0d: rate exp %h got %h, variance exp %h got %h",
                        responses_seen, want.filtered_rate, got.filtered_rate,
                        want.estimate_variance, got.estimate_variance);
         end
      endfunction
   endclass

   logic                 clock       = 1'b0;
   logic                 reset       = 1'b1;
   logic                 req_valid   = 1'b0;
   logic                 req_ready;
   req_payload_type      req_payload = '0;
   logic                 rsp_valid;
   logic                 rsp_ready   = 1'b0;
   rsp_payload_type      rsp_payload;
   logic                 csr_wr_en   = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index   = '0;
   logic [31:0]          csr_wr_data = '0;

   bit                   req_idle_on = 1'b1;
   bit                   rsp_idle_on = 1'b1;
   kalman_rate_checker   board       = new();

   scalar_kalman_rate_filter dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   // One request: optional gap, then hold valid until taken
   task automatic send_request(input logic func, input logic [31:0] rate);
      int gap;
      gap = req_idle_on ? $urandom_range(0, 8) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= '{func: func, rate_value: rate};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_request(req_payload);
   endtask

   // Stop sending, wait for every owed estimate, then let the filter go quiet
   task automatic settle_idle();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Caller lowers the write enable after the last write of a batch
   task automatic write_csr(input logic [CSR_IDX_W-1:0] index, input logic [31:0] value);
      csr_wr_en   <= 1'b1;
      csr_index   <= index;
      csr_wr_data <= value;
      @(posedge clock);
      board.write_register(index, value);
   endtask

   task automatic apply_settings(input logic [31:0] init_var, input logic [31:0] motion_var,
                                 input logic [31:0] meas_var, input bit touch_unmapped);
      write_csr(CSR_INITIAL_VARIANCE, init_var);
      write_csr(CSR_MOTION_VARIANCE, motion_var);
      write_csr(CSR_MEASUREMENT_VARIANCE, meas_var);
      if (touch_unmapped) write_csr(CSR_UNMAPPED, $urandom);
      csr_wr_en <= 1'b0;
   endtask

   // Variance setting: extremes, realistic values and anything at all
   function automatic logic [31:0] pick_variance(input bit zero_ok);
      logic [31:0] v;
      case ($urandom_range(0, 5))
         0:       v = zero_ok ? 32'd0 : 32'd1;
         1:       v = 32'hFFFF_FFFF;
         2, 3:    v = $urandom_range(32'h0000_1000, 32'h0040_0000);
         default: v = $urandom;
      endcase
      if (v == 32'd0 && !zero_ok) v = 32'd1;
      return v;
   endfunction

   // Mostly plausible yaw rates within +-16 rad/s, sometimes any bit pattern
   function automatic logic [31:0] pick_rate();
      logic [31:0] r;
      if ($urandom_range(0, 9) < 7) r = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
      else r = $urandom;
      return r;
   endfunction

   task automatic run_random_phase(input int rounds);
      for (int i = 0; i < rounds; i++) begin
         if ($urandom_range(0, 9) < 4) send_request(FUNC_IMU, pick_rate());
         send_request(FUNC_ODOMETRY, pick_rate());
      end
   endtask

   // Response side: random stalls, one long hold-off to back the filter up
   initial begin : response_side
      int wait_cycles;
      while (reset) @(posedge clock);
      forever begin
         wait_cycles = rsp_idle_on ? $urandom_range(0, 8) : 0;
         if (board.responses_seen == HOLD_OFF_AT) wait_cycles = HOLD_OFF_CYCLES;
         if (wait_cycles > 0) begin
            rsp_ready <= 1'b0;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         board.check_response(rsp_payload);
      end
   end

   // Request side and run control
   initial begin : stimulus
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // seed variance at an extreme, or left at its default
      case ($urandom_range(0, 2))
         1:       write_csr(CSR_INITIAL_VARIANCE, 32'd1);
         2:       write_csr(CSR_INITIAL_VARIANCE, 32'hFFFF_FFFF);
         default: ;
      endcase
      csr_wr_en <= 1'b0;

      // default settings: seeding, fusing before any imu, extreme rates
      send_request(FUNC_ODOMETRY, 32'h0005_0000);
      send_request(FUNC_ODOMETRY, 32'h0006_0000);
      send_request(FUNC_IMU, 32'h7FFF_FFFF);
      send_request(FUNC_ODOMETRY, 32'h7FFF_FFFF);
      send_request(FUNC_ODOMETRY, 32'h8000_0000);
      send_request(FUNC_IMU, 32'h8000_0000);
      send_request(FUNC_ODOMETRY, 32'h7FFF_FFFF);
      send_request(FUNC_IMU, 32'h0000_0000);
      send_request(FUNC_ODOMETRY, 32'h0000_0000);
      send_request(FUNC_IMU, 32'hFFFF_FFFF);
      send_request(FUNC_ODOMETRY, 32'hFFFF_FFFF);
      send_request(FUNC_ODOMETRY, 32'h0000_0001);
      send_request(FUNC_IMU, 32'hFFFD_8000);
      send_request(FUNC_ODOMETRY, 32'hFFFD_8000);

      // huge motion and measurement noise: variance saturates in prediction
      settle_idle();
      apply_settings(32'h0000_0001, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
      send_request(FUNC_IMU, 32'h0003_0000);
      send_request(FUNC_ODOMETRY, 32'h0001_0000);
      send_request(FUNC_ODOMETRY, 32'h0002_0000);
      send_request(FUNC_ODOMETRY, 32'hFFFF_0000);

      // no motion noise, tiny measurement noise: mean swings to both limits
      settle_idle();
      apply_settings(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0001, 1'b0);
      send_request(FUNC_IMU, 32'h7FFF_0000);
      send_request(FUNC_ODOMETRY, 32'h7FFF_FFFF);
      send_request(FUNC_ODOMETRY, 32'h8000_0000);
      send_request(FUNC_ODOMETRY, 32'h0000_0000);
      send_request(FUNC_ODOMETRY, 32'h7FFF_FFFF);
      send_request(FUNC_ODOMETRY, 32'h8000_0000);

      // random phases, each under fresh settings; phase 1 runs flat out
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         settle_idle();
         apply_settings(pick_variance(1'b0), pick_variance(1'b1), pick_variance(1'b0),
                        $urandom_range(0, 1));
         req_idle_on = (phase != 1) && ($urandom_range(0, 3) != 0);
         rsp_idle_on = (phase != 1) && ($urandom_range(0, 3) != 0);
         run_random_phase(PHASE_ROUNDS);
      end

      settle_idle();
      if (board.failures == 0 && board.pending() == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

   // Watchdog
   initial begin : watchdog
      #5_000_000;
      $display("tb_top NOT OK");
      $finish;
   end

endmodule
